[rtl/message_queue_drop_oldest_assert.svh]
// Assertion macros shared by the message queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MESSAGE_QUEUE_DROP_OLDEST_ASSERT_SVH
`define MESSAGE_QUEUE_DROP_OLDEST_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define MQDO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define MQDO_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/mqdo_pkg.sv]
// Package for the message queue: item structs, mode codes, state encoding.
// Depends on nothing.
`default_nettype none

package mqdo_pkg;

    localparam int LEN_W  = 7;
    localparam int DATA_W = 8;
    localparam int OVF_W  = 32;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_SEND   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data_in;
        logic              end_of_message;
        logic              dma_busy;
    } t_in_item;

    typedef struct packed {
        logic              sent;
        logic              byte_valid;
        logic [DATA_W-1:0] data_out;
        logic [LEN_W-1:0]  message_length;
        logic              last_result;
        logic [OVF_W-1:0]  overflow_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_META  = 3'b010,
        S_BYTES = 3'b100
    } t_state;

endpackage

`default_nettype wire

[rtl/message_queue_drop_oldest.sv]
// Top level of the drop-oldest message queue: slot table, byte RAM, control.
// Depends on mqdo_pkg, mqdo_ram and message_queue_drop_oldest_assert.svh.
`default_nettype none
`include "message_queue_drop_oldest_assert.svh"

// Two-level transmit queue. Append items (mode 0) build a message in the
// open slot; the first byte of each message is discarded and a byte with
// end_of_message commits it. Starting a message while all slots hold
// committed messages drops the oldest and bumps overflow_count. Within a
// slot a full byte ring overwrites its oldest byte. A send item (mode 1)
// is refused with one status item when dma_busy is set or nothing is
// queued; otherwise the oldest message comes out one item per byte, oldest
// first, or as one item with sent=1 and no byte if the message is empty.
// An append or a refused send is handled in S_IDLE. A send goes through
// S_META, where the registered slot table read returns, then S_BYTES,
// which emits each registered byte RAM read and holds while the output stalls.
// Both memories come up uninitialized and need no clearing pass.
module message_queue_drop_oldest #(
    parameter int MESSAGE_SLOTS     = 8,
    parameter int BYTES_PER_MESSAGE = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire mqdo_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output mqdo_pkg::t_out_item      o_item
);

    localparam int SLOT_W = $clog2(MESSAGE_SLOTS);
    localparam int PTR_W  = $clog2(BYTES_PER_MESSAGE);
    localparam int CNT_W  = $clog2(BYTES_PER_MESSAGE + 1);
    localparam int Q_W    = $clog2(MESSAGE_SLOTS + 1);
    localparam int ADDR_W = $clog2(MESSAGE_SLOTS * BYTES_PER_MESSAGE);
    localparam int META_W = CNT_W + PTR_W;

    function automatic logic [PTR_W-1:0] f_ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BYTES_PER_MESSAGE - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] f_slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(MESSAGE_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    // Control and queue state
    mqdo_pkg::t_state    r_state, n_state;
    logic [SLOT_W-1:0]   r_write_slot, n_write_slot;
    logic [SLOT_W-1:0]   r_read_slot, n_read_slot;
    logic [Q_W-1:0]      r_queued, n_queued;
    logic [31:0]         r_overflow, n_overflow;
    logic                r_inside, n_inside;
    // Open message ring pointers
    logic [CNT_W-1:0]    r_open_cnt, n_open_cnt;
    logic [PTR_W-1:0]    r_open_wptr, n_open_wptr;
    logic [PTR_W-1:0]    r_open_rptr, n_open_rptr;
    // Send walk
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0]    r_len, n_len;
    logic [CNT_W-1:0]    r_remain, n_remain;
    // Output register
    logic                r_out_valid, n_out_valid;
    mqdo_pkg::t_out_item r_out, n_out;

    // Memory ports
    logic                byte_wr_en;
    logic [ADDR_W-1:0]   byte_wr_addr;
    logic                byte_rd_en;
    logic [ADDR_W-1:0]   byte_rd_addr;
    logic [7:0]          byte_rd_data;
    logic                meta_wr_en;
    logic [META_W-1:0]   meta_wr_data;
    logic                meta_rd_en;
    logic [META_W-1:0]   meta_rd_data;
    logic [CNT_W-1:0]    meta_cnt;
    logic [PTR_W-1:0]    meta_rptr;

    logic                out_free;
    logic                accept;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == mqdo_pkg::S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign {meta_cnt, meta_rptr} = meta_rd_data;

    // Byte store: every slot is one ring of bytes
    mqdo_ram #(
        .WIDTH (8),
        .DEPTH (MESSAGE_SLOTS * BYTES_PER_MESSAGE)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_wr_en   (byte_wr_en),
        .i_wr_addr (byte_wr_addr),
        .i_wr_data (i_item.data_in),
        .i_rd_en   (byte_rd_en),
        .i_rd_addr (byte_rd_addr),
        .o_rd_data (byte_rd_data)
    );

    // Slot table: count and read pointer of each committed message
    mqdo_ram #(
        .WIDTH (META_W),
        .DEPTH (MESSAGE_SLOTS)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_wr_en),
        .i_wr_addr (r_write_slot),
        .i_wr_data (meta_wr_data),
        .i_rd_en   (meta_rd_en),
        .i_rd_addr (r_read_slot),
        .o_rd_data (meta_rd_data)
    );

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_queued     = r_queued;
        n_overflow   = r_overflow;
        n_inside     = r_inside;
        n_open_cnt   = r_open_cnt;
        n_open_wptr  = r_open_wptr;
        n_open_rptr  = r_open_rptr;
        n_base       = r_base;
        n_ptr        = r_ptr;
        n_len        = r_len;
        n_remain     = r_remain;
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        byte_wr_en   = 1'b0;
        byte_wr_addr = ADDR_W'(r_write_slot) * ADDR_W'(BYTES_PER_MESSAGE)
                       + ADDR_W'(r_open_wptr);
        byte_rd_en   = 1'b0;
        byte_rd_addr = r_base + ADDR_W'(r_ptr);
        meta_wr_en   = 1'b0;
        meta_wr_data = '0;
        meta_rd_en   = 1'b0;

        case (r_state)
            mqdo_pkg::S_IDLE: begin
                if (accept && i_item.mode == mqdo_pkg::MODE_APPEND) begin
                    if (!r_inside) begin
                        // Open a message: drop the oldest if the ring is full
                        if (r_queued >= Q_W'(MESSAGE_SLOTS)) begin
                            n_read_slot = f_slot_inc(r_read_slot);
                            n_queued    = Q_W'(MESSAGE_SLOTS - 1);
                            n_overflow  = r_overflow + 32'd1;
                        end
                        n_open_cnt  = '0;
                        n_open_wptr = '0;
                        n_open_rptr = '0;
                        n_inside    = 1'b1;
                    end else begin
                        // Store the byte, overwrite the oldest when full
                        byte_wr_en  = 1'b1;
                        n_open_wptr = f_ptr_inc(r_open_wptr);
                        if (r_open_cnt < CNT_W'(BYTES_PER_MESSAGE)) begin
                            n_open_cnt = r_open_cnt + 1'b1;
                        end else begin
                            n_open_rptr = f_ptr_inc(r_open_rptr);
                        end
                    end
                    if (i_item.end_of_message) begin
                        // Commit the message into the slot table
                        meta_wr_en   = 1'b1;
                        meta_wr_data = {n_open_cnt, n_open_rptr};
                        n_write_slot = f_slot_inc(r_write_slot);
                        if (n_queued < Q_W'(MESSAGE_SLOTS)) begin
                            n_queued = n_queued + 1'b1;
                        end
                        n_inside = 1'b0;
                    end
                    n_out_valid = 1'b1;
                    n_out       = '{sent: 1'b0, byte_valid: 1'b0, data_out: '0,
                                    message_length: '0, last_result: 1'b1,
                                    overflow_count: n_overflow};
                end else if (accept) begin
                    if (i_item.dma_busy || r_queued == '0) begin
                        // Refuse the send
                        n_out_valid = 1'b1;
                        n_out       = '{sent: 1'b0, byte_valid: 1'b0, data_out: '0,
                                        message_length: '0, last_result: 1'b1,
                                        overflow_count: r_overflow};
                    end else begin
                        // Take the oldest slot and fetch its table entry
                        meta_rd_en  = 1'b1;
                        n_base      = ADDR_W'(r_read_slot)
                                      * ADDR_W'(BYTES_PER_MESSAGE);
                        n_read_slot = f_slot_inc(r_read_slot);
                        n_queued    = r_queued - 1'b1;
                        n_state     = mqdo_pkg::S_META;
                    end
                end
            end
            mqdo_pkg::S_META: begin
                if (meta_cnt == '0) begin
                    // Empty message: one item, no byte
                    n_out_valid = 1'b1;
                    n_out       = '{sent: 1'b1, byte_valid: 1'b0, data_out: '0,
                                    message_length: '0, last_result: 1'b1,
                                    overflow_count: r_overflow};
                    n_state     = mqdo_pkg::S_IDLE;
                end else begin
                    // Start the byte walk at the oldest byte
                    byte_rd_en   = 1'b1;
                    byte_rd_addr = r_base + ADDR_W'(meta_rptr);
                    n_ptr        = f_ptr_inc(meta_rptr);
                    n_len        = meta_cnt;
                    n_remain     = meta_cnt - 1'b1;
                    n_state      = mqdo_pkg::S_BYTES;
                end
            end
            mqdo_pkg::S_BYTES: begin
                if (out_free) begin
                    // Emit the fetched byte and advance the walk
                    n_out_valid = 1'b1;
                    n_out       = '{sent: 1'b1, byte_valid: 1'b1,
                                    data_out: byte_rd_data,
                                    message_length: mqdo_pkg::LEN_W'(r_len),
                                    last_result: (r_remain == '0),
                                    overflow_count: r_overflow};
                    if (r_remain != '0) begin
                        byte_rd_en = 1'b1;
                        n_ptr      = f_ptr_inc(r_ptr);
                        n_remain   = r_remain - 1'b1;
                    end else begin
                        n_state = mqdo_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = mqdo_pkg::S_IDLE;
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mqdo_pkg::S_IDLE;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_queued     <= '0;
            r_overflow   <= '0;
            r_inside     <= 1'b0;
            r_open_cnt   <= '0;
            r_open_wptr  <= '0;
            r_open_rptr  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_queued     <= n_queued;
            r_overflow   <= n_overflow;
            r_inside     <= n_inside;
            r_open_cnt   <= n_open_cnt;
            r_open_wptr  <= n_open_wptr;
            r_open_rptr  <= n_open_rptr;
            r_out_valid  <= n_out_valid;
        end
        r_base   <= n_base;
        r_ptr    <= n_ptr;
        r_len    <= n_len;
        r_remain <= n_remain;
        r_out    <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // Assertions
    `MQDO_NEVER(a_queue_bound, i_clk, i_rst_n, r_queued > Q_W'(MESSAGE_SLOTS),
        "queued message count above slot count")
    `MQDO_ASSERT(a_open_leaves_room, i_clk, i_rst_n,
        r_inside |-> (r_queued < Q_W'(MESSAGE_SLOTS)),
        "open message shares its slot with a committed one")
    `MQDO_ASSERT(a_meta_one_cycle, i_clk, i_rst_n,
        (r_state == mqdo_pkg::S_META) |=> (r_state != mqdo_pkg::S_META),
        "slot table fetch lasted more than one cycle")
    `MQDO_ASSERT(a_walk_len, i_clk, i_rst_n,
        (r_state == mqdo_pkg::S_BYTES) |-> (r_len != '0 && r_remain < r_len),
        "byte walk with bad length or remainder")
    `MQDO_ASSERT(a_byte_has_len, i_clk, i_rst_n,
        (r_out_valid && r_out.byte_valid) |-> (r_out.sent && r_out.message_length != '0),
        "byte item without a message length")

endmodule

`default_nettype wire

[rtl/mqdo_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module mqdo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, and hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[verif/message_queue_drop_oldest_tb.sv]
// Self-checking testbench for the drop-oldest message queue.
// Depends on mqdo_pkg and the message_queue_drop_oldest RTL.
module message_queue_drop_oldest_tb;

    localparam int SLOTS       = 8;
    localparam int BYTES       = 64;
    localparam int HALF_PERIOD = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = BYTES + 8;
    localparam int MAX_PRINTS  = 100;
    localparam int IN_W        = $bits(mqdo_pkg::t_in_item);
    localparam longint RUN_LIMIT = 64'd10_000_000;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_ready = 1'b0;
    mqdo_pkg::t_in_item  i_item  = '0;
    logic                o_ready;
    logic                o_valid;
    mqdo_pkg::t_out_item o_item;

    // Sender idle and receiver stall odds, in percent
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_req     = 1'b0;
    logic        rx_hold      = 1'b0;

    int unsigned fail_count  = 0;
    int unsigned result_seen = 0;

    // Queue mirror: byte rings, slot pointers and message bookkeeping
    logic [7:0]  slot_bytes [SLOTS][BYTES];
    int unsigned slot_count [SLOTS];
    int unsigned slot_wptr  [SLOTS];
    int unsigned slot_rptr  [SLOTS];
    int unsigned wr_slot    = 0;
    int unsigned rd_slot    = 0;
    int unsigned committed  = 0;
    logic [31:0] drop_count = '0;
    logic        building   = 1'b0;

    // Output items the mirror says are still owed, oldest first
    mqdo_pkg::t_out_item due_items [$];

    message_queue_drop_oldest #(
        .MESSAGE_SLOTS     (SLOTS),
        .BYTES_PER_MESSAGE (BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Drive receiver ready: held low on request, random stalls otherwise
    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Hold off the receiver when asked, then release it and clear the request
    initial begin
        forever begin
            wait (hold_req);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold  <= 1'b0;
            hold_req = 1'b0;
        end
    end

    function automatic void clear_slot(input int unsigned s);
        slot_count[s] = 0;
        slot_wptr[s]  = 0;
        slot_rptr[s]  = 0;
        for (int b = 0; b < BYTES; b++) slot_bytes[s][b] = '0;
    endfunction

    function automatic mqdo_pkg::t_out_item make_out(input logic sent, input logic byte_ok,
                                                     input logic [7:0] data,
                                                     input logic [6:0] len,
                                                     input logic last);
        mqdo_pkg::t_out_item r;
        r.sent           = sent;
        r.byte_valid     = byte_ok;
        r.data_out       = data;
        r.message_length = len;
        r.last_result    = last;
        r.overflow_count = drop_count;
        return r;
    endfunction

    // Advance the queue mirror by one accepted item and queue its outputs
    function automatic void step_queue(input mqdo_pkg::t_in_item it);
        int unsigned len;
        int unsigned p;
        if (it.mode == mqdo_pkg::MODE_APPEND) begin
            if (!building) begin
                // start a message: drop the oldest one if every slot is taken
                if (committed >= SLOTS) begin
                    rd_slot    = (rd_slot + 1) % SLOTS;
                    committed  = SLOTS - 1;
                    drop_count = drop_count + 1;
                end
                clear_slot(wr_slot);
                building = 1'b1;
            end else begin
                // store the byte, overwriting the oldest one when the ring is full
                slot_bytes[wr_slot][slot_wptr[wr_slot]] = it.data_in;
                slot_wptr[wr_slot] = (slot_wptr[wr_slot] + 1) % BYTES;
                if (slot_count[wr_slot] < BYTES) begin
                    slot_count[wr_slot]++;
                end else begin
                    slot_rptr[wr_slot] = (slot_rptr[wr_slot] + 1) % BYTES;
                end
            end
            if (it.end_of_message) begin
                wr_slot = (wr_slot + 1) % SLOTS;
                if (committed < SLOTS) committed++;
                building = 1'b0;
            end
            due_items.push_back(make_out(1'b0, 1'b0, 8'h00, 7'd0, 1'b1));
        end else if (it.dma_busy || committed == 0) begin
            due_items.push_back(make_out(1'b0, 1'b0, 8'h00, 7'd0, 1'b1));
        end else begin
            len = slot_count[rd_slot];
            p   = slot_rptr[rd_slot];
            if (len == 0) begin
                due_items.push_back(make_out(1'b1, 1'b0, 8'h00, 7'd0, 1'b1));
            end else begin
                for (int g = 0; g < len; g++) begin
                    due_items.push_back(make_out(1'b1, 1'b1, slot_bytes[rd_slot][p],
                                                 7'(len), (g + 1 == len)));
                    p = (p + 1) % BYTES;
                end
            end
            clear_slot(rd_slot);
            committed--;
            rd_slot = (rd_slot + 1) % SLOTS;
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_PRINTS) $display("mismatch: %s", what);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      result_seen, name, got, want));
        end
    endtask

    task automatic check_result(input mqdo_pkg::t_out_item got);
        mqdo_pkg::t_out_item want;
        if (due_items.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none owed: %h",
                                      result_seen, got));
        end else begin
            want = due_items.pop_front();
            compare_field("sent", 32'(got.sent), 32'(want.sent));
            compare_field("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
            compare_field("data_out", 32'(got.data_out), 32'(want.data_out));
            compare_field("message_length", 32'(got.message_length),
                          32'(want.message_length));
            compare_field("last_result", 32'(got.last_result), 32'(want.last_result));
            compare_field("overflow_count", got.overflow_count, want.overflow_count);
        end
        result_seen++;
    endtask

    // Predict on each accepted item, then check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) step_queue(i_item);
            if (o_valid && i_ready) check_result(o_item);
        end
    end

    // Offer one item after a random idle gap and hold it until accepted
    task automatic send_item(input mqdo_pkg::t_in_item it);
        while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic append_byte(input logic [7:0] data, input logic eom);
        mqdo_pkg::t_in_item it;
        it.mode           = mqdo_pkg::MODE_APPEND;
        it.data_in        = data;
        it.end_of_message = eom;
        it.dma_busy       = 1'($urandom_range(1, 0));
        send_item(it);
    endtask

    task automatic request_send(input logic busy);
        mqdo_pkg::t_in_item it;
        it.mode           = mqdo_pkg::MODE_SEND;
        it.data_in        = 8'($urandom);
        it.end_of_message = 1'($urandom_range(1, 0));
        it.dma_busy       = busy;
        send_item(it);
    endtask

    // Append a whole message of n items with random bytes
    task automatic put_message(input int n);
        for (int i = 0; i < n; i++) append_byte(8'($urandom), (i == n - 1));
    endtask

    // Lower valid and wait until every owed result has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (due_items.size() != 0) @(posedge i_clk);
    endtask

    // Refused sends, empty messages, byte extremes, send while building
    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        request_send(1'b0);
        request_send(1'b1);
        append_byte(8'hFF, 1'b1);
        request_send(1'b0);
        append_byte(8'h00, 1'b0);
        append_byte(8'hFF, 1'b0);
        append_byte(8'h00, 1'b0);
        append_byte(8'hA5, 1'b1);
        append_byte(8'h5A, 1'b0);
        append_byte(8'h12, 1'b0);
        request_send(1'b1);
        request_send(1'b0);
        request_send(1'b0);
        append_byte(8'h34, 1'b1);
        request_send(1'b0);
        wait_drained();
    endtask

    // Fill every slot, overrun by two messages, then drain past empty
    task automatic test_queue_overflow();
        tx_idle_pct  = 15;
        rx_stall_pct = 15;
        for (int m = 0; m < SLOTS + 2; m++) put_message(2 + m % 3);
        repeat (SLOTS + 1) request_send(1'b0);
        wait_drained();
    endtask

    // Exactly full byte ring, then one that overwrites its oldest bytes
    task automatic test_slot_wrap();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        put_message(BYTES + 1);
        put_message(BYTES + 6);
        request_send(1'b0);
        request_send(1'b0);
        wait_drained();
    endtask

    // Block the receiver while the sender keeps pushing until input stalls
    task automatic test_receiver_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b1;
        repeat (6) put_message(6);
        repeat (3) request_send(1'b0);
        wait_drained();
    endtask

    // Mostly well-formed messages and sends, some noise items
    task automatic test_random_traffic(input int n_items, input int tx_idle,
                                       input int rx_stall);
        int                 done_items;
        int                 pick;
        int                 len;
        mqdo_pkg::t_in_item it;
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        done_items   = 0;
        while (done_items < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 50) begin
                // short messages, now and then a long one that can wrap its slot
                len = ($urandom_range(19, 0) == 0) ? $urandom_range(70, 40)
                                                   : $urandom_range(8, 1);
                for (int i = 0; i < len; i++) begin
                    append_byte(8'($urandom), (i == len - 1));
                    if (i != len - 1 && $urandom_range(19, 0) == 0) begin
                        request_send(1'b0);
                        done_items++;
                    end
                end
                done_items += len;
            end else if (pick < 90) begin
                request_send($urandom_range(4, 0) == 0);
                done_items++;
            end else begin
                it = IN_W'($urandom);
                send_item(it);
                done_items++;
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed();
        test_queue_overflow();
        test_slot_wrap();
        test_receiver_hold();
        test_random_traffic(20, 0, 0);
        test_random_traffic(20, 77, 0);
        test_random_traffic(20, 0, 77);
        test_random_traffic(20, 15, 15);

        // Let any stray result surface before judging
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_items.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", due_items.size()));
        end
        if (fail_count == 0) begin
            $display("message_queue_drop_oldest regression: pass");
        end else begin
            $display("message_queue_drop_oldest regression: fail");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(RUN_LIMIT);
        $display("message_queue_drop_oldest regression: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/mqdo_pkg.sv
rtl/mqdo_ram.sv
rtl/message_queue_drop_oldest.sv
verif/message_queue_drop_oldest_tb.sv
